FILE: rtl/core/lcd_pkg.sv
// ----------------------------------------------------------------------------
// Line centroid detector package
// Sizes, codes, reset values and the types shared by the detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcd_pkg;

   localparam int ROW_WIDTH = 320;
   localparam int PIX_W     = 8;
   localparam int POS_W     = $clog2(ROW_WIDTH + 1);
   localparam int POS_AW    = $clog2(ROW_WIDTH);
   localparam int RAM_AW    = POS_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;
   localparam int HALF      = ROW_WIDTH / 2;
   localparam int SUM_W     = $clog2(ROW_WIDTH * ROW_WIDTH / 4 + 1) + 1;
   localparam int STEP_W    = $clog2(SUM_W);

   localparam int STATUS_W  = 2;
   localparam int OFFSET_W  = 9;
   localparam int COUNT_W   = 9;
   localparam int COUNT_MAX = 2 ** COUNT_W - 1;
   localparam int DARK_W    = 8;
   localparam int WHITE_W   = 9;

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [DARK_W-1:0]  DARK_RESET  = 8'd60;
   localparam logic [WHITE_W-1:0] WHITE_RESET = 9'd280;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LINE  = 2'd0,
      STATUS_BLACK = 2'd1,
      STATUS_WHITE = 2'd2
   } status_type;

   typedef enum logic {
      REG_DARK  = 1'b0,
      REG_WHITE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic              bank;
      logic [POS_W-1:0]  len;
      logic [PIX_W-1:0]  thr;
      logic              black;
   } row_desc_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [PIX_W-1:0]  data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
   } ram_rd_type;

endpackage

FILE: rtl/core/lcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lcd_front.sv
// ----------------------------------------------------------------------------
// Line centroid detector front end
// Stores the pixels of a row into its bank, tracks min and max and hands a
// row descriptor to the queue at the last pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_front import lcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [PIX_W-1:0]  pixel,
   input  logic              last_pixel,
   input  logic [DARK_W-1:0] dark_limit,
   output ram_wr_type        ram_wr,
   output logic              push,
   output row_desc_type      push_desc
);

   logic [PIX_W-1:0] max_ff, max_in;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             bank_ff, bank_in;

   logic             store;
   logic             upd;
   logic [PIX_W-1:0] max_new;
   logic [PIX_W-1:0] min_new;
   logic [POS_W-1:0] pos_new;
   logic [PIX_W:0]   thr_sum;

   always_comb begin
      store   = pos_ff < POS_W'(ROW_WIDTH);
      upd     = accept & store;
      max_new = (upd && (pixel > max_ff)) ? pixel : max_ff;
      min_new = (upd && (pixel < min_ff)) ? pixel : min_ff;
      pos_new = upd ? pos_ff + 1'b1 : pos_ff;
      thr_sum = {1'b0, max_new} + {1'b0, min_new};

      ram_wr.en   = upd;
      ram_wr.addr = {bank_ff, pos_ff[POS_AW-1:0]};
      ram_wr.data = pixel;

      push            = accept & last_pixel;
      push_desc.bank  = bank_ff;
      push_desc.len   = pos_new;
      push_desc.thr   = thr_sum[PIX_W:1];
      push_desc.black = max_new < dark_limit;

      if (push) begin
         max_in  = '0;
         min_in  = '1;
         pos_in  = '0;
         bank_in = ~bank_ff;
      end else begin
         max_in  = max_new;
         min_in  = min_new;
         pos_in  = pos_new;
         bank_in = bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= '1;
         pos_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         pos_ff  <= pos_in;
         bank_ff <= bank_in;
      end
   end

endmodule

FILE: rtl/core/lcd_queue.sv
// ----------------------------------------------------------------------------
// Line centroid detector row queue
// Two-entry queue of row descriptors between front end and evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_queue import lcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  row_desc_type push_desc,
   input  logic         pop,
   output row_desc_type head,
   output logic         valid,
   output logic         full
);

   row_desc_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      head      = entry_ff[rd_ptr_ff];
      valid     = count_ff != 2'd0;
      full      = count_ff == 2'd2;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/lcd_back.sv
// ----------------------------------------------------------------------------
// Line centroid detector evaluator
// Sweeps a stored row, counts bright pixels, sums their offsets from the centre,
// divides the sum by the count one quotient bit a cycle, issues the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_back import lcd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  row_desc_type               desc,
   input  logic [WHITE_W-1:0]         white_limit,
   input  logic [PIX_W-1:0]           rd_data,
   output ram_rd_type                 ram_rd,
   output logic                       pop,
   output logic                       rsp_valid,
   output status_type                 rsp_status,
   output logic signed [OFFSET_W-1:0] rsp_offset,
   output logic [COUNT_W-1:0]         rsp_count
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SWEEP  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic [POS_W-1:0]            idx_ff, idx_in;
   logic                        rvalid_ff, rvalid_in;
   logic [POS_AW-1:0]           rpos_ff, rpos_in;
   logic [POS_W-1:0]            cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]            quo_ff, quo_in;
   logic [POS_W:0]              rem_ff, rem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        neg_ff, neg_in;
   status_type                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic signed [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [COUNT_W-1:0]          rsp_count_ff, rsp_count_in;

   logic                        issue;
   logic                        bright;
   logic signed [SUM_W-1:0]     term;
   logic [SUM_W-1:0]            abs_sum;
   logic [POS_W:0]              trial;
   logic                        fits;
   logic signed [SUM_W:0]       mean;

   always_comb begin
      issue   = (state_ff == ST_SWEEP) && (idx_ff < desc.len);
      bright  = rvalid_ff && (rd_data > desc.thr);
      term    = $signed({{(SUM_W - POS_AW){1'b0}}, rpos_ff}) - $signed(SUM_W'(HALF));
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      trial   = {rem_ff[POS_W-1:0], quo_ff[SUM_W-1]};
      fits    = trial >= {1'b0, cnt_ff};
      mean    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

      ram_rd.en   = issue;
      ram_rd.addr = {desc.bank, idx_ff[POS_AW-1:0]};

      state_in      = state_ff;
      idx_in        = idx_ff;
      rvalid_in     = 1'b0;
      rpos_in       = rpos_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      pop           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               idx_in  = '0;
               cnt_in  = '0;
               sum_in  = '0;
               quo_in  = '0;
               rem_in  = '0;
               step_in = '0;
               neg_in  = 1'b0;
               if (desc.black) begin
                  status_in = STATUS_BLACK;
                  state_in  = ST_EMIT;
               end else begin
                  state_in  = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            rvalid_in = issue;
            rpos_in   = idx_ff[POS_AW-1:0];
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (bright) begin
               cnt_in = cnt_ff + 1'b1;
               sum_in = sum_ff + term;
            end
            if (!issue && !rvalid_ff) begin
               if (32'(cnt_ff) >= 32'(white_limit)) begin
                  status_in = STATUS_WHITE;
                  state_in  = ST_EMIT;
               end else begin
                  status_in = STATUS_LINE;
                  if (cnt_ff == '0) begin
                     state_in = ST_EMIT;
                  end else begin
                     quo_in   = abs_sum;
                     neg_in   = sum_ff[SUM_W-1];
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = fits ? trial - {1'b0, cnt_ff} : trial;
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            pop           = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_offset_in = OFFSET_W'(mean);
            if (32'(cnt_ff) > COUNT_MAX) begin
               rsp_count_in = COUNT_W'(COUNT_MAX);
            end else begin
               rsp_count_in = COUNT_W'(cnt_ff);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rpos_ff       <= rpos_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_count  = rsp_count_ff;

   a_rsp_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EMIT))
      else $error("result item without emit");

   a_work_has_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> q_valid)
      else $error("evaluation without a queued row");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((idx_ff <= desc.len) && (cnt_ff <= desc.len)))
      else $error("sweep beyond stored row");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < {1'b0, cnt_ff}))
      else $error("division remainder out of range");

   a_black_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_BLACK))
         |-> ((rsp_count_ff == '0) && (rsp_offset_ff == '0)))
      else $error("all-black item with count or offset");

endmodule

FILE: rtl/core/line_centroid_detector_top.sv
// ----------------------------------------------------------------------------
// Line centroid detector
// One pixel per cycle into the front end while not busy; busy is high while both row banks wait.
// A line row is swept over its stored pixels, then divided one quotient bit a cycle;
// white rows and rows without bright pixels skip the division, black rows the sweep.
// Queued rows wait for the evaluator; the result item is registered out of the emit state.
// Reset: limits 60 and 280, queue and control cleared, store not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_centroid_detector_top import lcd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [PIX_W-1:0]           req_pixel,
   input  logic                       req_last_pixel,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [OFFSET_W-1:0] rsp_offset,
   output logic [COUNT_W-1:0]         rsp_bright_count,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_AW-1:0]          paddr,
   input  logic [CSR_DW-1:0]          pwdata,
   output logic [CSR_DW-1:0]          prdata,
   output logic                       pready
);

   logic [DARK_W-1:0]  dark_ff, dark_in;
   logic [WHITE_W-1:0] white_ff, white_in;

   logic          csr_wr;
   reg_index_type csr_index;
   logic          accept;
   logic          q_full;
   logic          q_valid;
   logic          push;
   logic          pop;
   row_desc_type  push_desc;
   row_desc_type  head;
   ram_wr_type    ram_wr;
   ram_rd_type    ram_rd;
   logic [PIX_W-1:0] rd_data;
   status_type    status;

   always_comb begin
      csr_wr    = psel & penable & pwrite;
      csr_index = reg_index_type'(paddr[2]);
      dark_in   = dark_ff;
      white_in  = white_ff;
      case (csr_index)
         REG_DARK: begin
            prdata = CSR_DW'(dark_ff);
            if (csr_wr) begin
               dark_in = pwdata[DARK_W-1:0];
            end
         end
         REG_WHITE: begin
            prdata = CSR_DW'(white_ff);
            if (csr_wr) begin
               white_in = pwdata[WHITE_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff  <= DARK_RESET;
         white_ff <= WHITE_RESET;
      end else begin
         dark_ff  <= dark_in;
         white_ff <= white_in;
      end
   end

   assign pready     = 1'b1;
   assign busy       = q_full;
   assign accept     = start & ~q_full;
   assign rsp_status = status;

   lcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel      (req_pixel),
      .last_pixel (req_last_pixel),
      .dark_limit (dark_ff),
      .ram_wr     (ram_wr),
      .push       (push),
      .push_desc  (push_desc)
   );

   lcd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RAM_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (rd_data)
   );

   lcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .valid     (q_valid),
      .full      (q_full)
   );

   lcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .desc        (head),
      .white_limit (white_ff),
      .rd_data     (rd_data),
      .ram_rd      (ram_rd),
      .pop         (pop),
      .rsp_valid   (rsp_strobe),
      .rsp_status  (status),
      .rsp_offset  (rsp_offset),
      .rsp_count   (rsp_bright_count)
   );

endmodule
